// ===== design/srfd_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package srfd_pkg;

  // Widths fixed by the register map and the beat formats.
  localparam int unsigned PayloadSizeW = 7;
  localparam int unsigned IdleW        = 16;
  localparam int unsigned CfgIndexW    = 1;
  localparam int unsigned CfgDataW     = 16;
  localparam int unsigned WordW        = 32;
  localparam int unsigned NumWords     = 5;
  localparam int unsigned WordIdxW     = 3;
  localparam int unsigned RecCountW    = 4;

  localparam logic [PayloadSizeW-1:0] PayloadSizeReset = 7'd24;
  localparam logic [IdleW-1:0]        IdleLimitReset   = 16'd100;

  // Register indexes on the configuration channel.
  localparam logic [CfgIndexW-1:0] CFG_PAYLOAD_SIZE = 1'b0;
  localparam logic [CfgIndexW-1:0] CFG_IDLE_LIMIT   = 1'b1;

  // Input operations.
  localparam logic OP_BYTE = 1'b0;
  localparam logic OP_TICK = 1'b1;

  // Record tags (ASCII).
  localparam logic [7:0] TAG_T = 8'h54;
  localparam logic [7:0] TAG_D = 8'h44;
  localparam logic [7:0] TAG_P = 8'h50;
  localparam logic [7:0] TAG_S = 8'h53;

  // Value byte counts of the two record lengths.
  localparam logic [RecCountW-1:0] LEN_DOUBLE = 4'd8;
  localparam logic [RecCountW-1:0] LEN_SINGLE = 4'd4;

  typedef enum logic [1:0] {
    PH_TAG     = 2'd0,
    PH_VALUE   = 2'd1,
    PH_STOPPED = 2'd2
  } phase_e;

  typedef enum logic [1:0] {
    KIND_T = 2'd0,
    KIND_D = 2'd1,
    KIND_P = 2'd2,
    KIND_S = 2'd3
  } kind_e;

  typedef struct packed {
    logic       operation;
    logic [7:0] byte_value;
  } in_beat_t;

  typedef struct packed {
    logic [CfgIndexW-1:0] reg_index;
    logic [CfgDataW-1:0]  wr_data;
  } cfg_beat_t;

  typedef struct packed {
    logic [WordW-1:0] temperature_first;
    logic [WordW-1:0] temperature_second;
    logic [WordW-1:0] deflection_word;
    logic [WordW-1:0] pressure_word;
    logic [WordW-1:0] chip_temperature_word;
    logic             has_temperature;
    logic             has_deflection;
    logic             has_pressure;
    logic             has_chip_temperature;
    logic             decode_stopped;
    logic [WordW-1:0] message_count;
  } result_t;

endpackage

`default_nettype wire

// ===== design/srfd_chan_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface srfd_chan_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== design/sensor_record_frame_decoder.sv =====
// Sensor record frame decoder. Each input beat is either a received byte or a
// one-millisecond tick. Bytes are counted into frames of payload_size bytes
// (register 0, clamped to 1..MAX_PAYLOAD) and decoded as they arrive as tagged
// records: 'T' carries two little-endian 32-bit words, 'D', 'P' and 'S' one
// each. A record whose value bytes would run past the end of the frame, or an
// unknown tag, stops decoding for the rest of that frame. When the last byte of
// a frame is taken, one result beat carries the five words (zero where no
// record arrived), the presence flags, the stop flag and a wrapping frame
// count. Ticks never give a result; once more ticks than idle_limit_ticks
// (register 1) have passed since the last byte, a partial frame is thrown
// away. The block takes one beat per clock: the whole per-byte update is one
// level of logic into the state registers. A completed frame enters the output
// queue at the edge that takes its last byte and is offered on the output from
// the next cycle, unless an earlier result is still waiting ahead of it.
// Results go through a two-entry output queue, so input keeps flowing while
// one result is waiting; input ready drops only while two results are waiting.
// Configuration is always ready and should only be written while the block is
// idle.
`timescale 1ns / 1ps
`default_nettype none

module sensor_record_frame_decoder #(
  parameter int unsigned MAX_PAYLOAD = 64
) (
  input  wire          clk_i,
  input  wire          rst_ni,
  srfd_chan_if.sink    cfg_i,
  srfd_chan_if.sink    in_i,
  srfd_chan_if.source  out_o
);
  import srfd_pkg::*;

  // Frame position holds 0..MAX_PAYLOAD-1, the frame size 1..MAX_PAYLOAD.
  localparam int unsigned PW = $clog2(MAX_PAYLOAD);
  localparam int unsigned SW = $clog2(MAX_PAYLOAD + 1);
  localparam int unsigned CW = (SW > PayloadSizeW) ? SW : PayloadSizeW;

  // Configuration registers.
  logic [PayloadSizeW-1:0] payload_size_q;
  logic [IdleW-1:0]        idle_limit_q;

  // Decoder state.
  logic [PW-1:0]          pos_q, pos_d;
  phase_e                 phase_q, phase_d;
  kind_e                  kind_q, kind_d;
  logic [2:0]             cnt_q, cnt_d;
  logic [WordW-1:0]       words_q [NumWords];
  logic [WordW-1:0]       words_d [NumWords];
  logic [3:0]             flags_q, flags_d;
  logic                   stop_q, stop_d;
  logic [IdleW-1:0]       idle_q, idle_d;
  logic [WordW-1:0]       frames_q, frames_d;

  logic                   in_fire;
  logic                   q_full;
  logic                   push;
  result_t                result;

  // Per-byte combinational terms.
  logic [SW-1:0]          frame_size;
  logic [CW-1:0]          size_ext;
  logic [SW-1:0]          pos_inc;
  logic                   frame_done;
  logic [IdleW-1:0]       idle_inc;

  assign cfg_i.ready = 1'b1;
  assign in_i.ready  = !q_full;
  assign in_fire     = in_i.valid && in_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      payload_size_q <= PayloadSizeReset;
      idle_limit_q   <= IdleLimitReset;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.data.reg_index)
        CFG_PAYLOAD_SIZE: payload_size_q <= cfg_i.data.wr_data[PayloadSizeW-1:0];
        CFG_IDLE_LIMIT:   idle_limit_q   <= cfg_i.data.wr_data[IdleW-1:0];
        default:          ;
      endcase
    end
  end

  // Effective frame size: zero counts as one, anything above the buffer
  // depth is capped at it.
  always_comb begin
    size_ext = CW'(payload_size_q);
    if (payload_size_q == '0) begin
      frame_size = SW'(1);
    end else if (size_ext > CW'(MAX_PAYLOAD)) begin
      frame_size = SW'(MAX_PAYLOAD);
    end else begin
      frame_size = size_ext[SW-1:0];
    end
  end

  // A position left at or past a lowered size ends the frame on the next byte.
  assign pos_inc    = SW'(pos_q) + SW'(1);
  assign frame_done = (pos_inc >= frame_size);
  assign idle_inc   = (idle_q == '1) ? idle_q : idle_q + IdleW'(1);

  always_comb begin
    logic [RecCountW-1:0] rec_len;
    logic                 tag_ok;
    kind_e                tag_kind;
    logic [WordIdxW-1:0]  widx;
    logic [RecCountW-1:0] cnt_next;
    logic [RecCountW-1:0] rec_total;

    pos_d    = pos_q;
    phase_d  = phase_q;
    kind_d   = kind_q;
    cnt_d    = cnt_q;
    words_d  = words_q;
    flags_d  = flags_q;
    stop_d   = stop_q;
    idle_d   = idle_q;
    frames_d = frames_q;
    push     = 1'b0;

    rec_len   = LEN_SINGLE;
    tag_ok    = 1'b1;
    tag_kind  = KIND_T;
    widx      = '0;
    cnt_next  = {1'b0, cnt_q} + RecCountW'(1);
    rec_total = (kind_q == KIND_T) ? LEN_DOUBLE : LEN_SINGLE;

    unique case (in_i.data.byte_value)
      TAG_T: begin
        tag_kind = KIND_T;
        rec_len  = LEN_DOUBLE;
      end
      TAG_D:   tag_kind = KIND_D;
      TAG_P:   tag_kind = KIND_P;
      TAG_S:   tag_kind = KIND_S;
      default: tag_ok = 1'b0;
    endcase

    if (kind_q == KIND_T) begin
      widx = (cnt_q[2] == 1'b0) ? WordIdxW'(0) : WordIdxW'(1);
    end else begin
      widx = WordIdxW'(kind_q) + WordIdxW'(1);
    end

    if (in_fire && in_i.data.operation == OP_TICK) begin
      idle_d = idle_inc;
      // Drop a partial frame after too long a gap.
      if (pos_q != '0 && idle_inc > idle_limit_q) begin
        pos_d   = '0;
        phase_d = PH_TAG;
        kind_d  = KIND_T;
        cnt_d   = '0;
        for (int w = 0; w < NumWords; w++) begin
          words_d[w] = '0;
        end
        flags_d = '0;
        stop_d  = 1'b0;
      end
    end else if (in_fire) begin
      idle_d = '0;

      unique case (phase_q)
        PH_TAG: begin
          if (tag_ok && ({1'b0, pos_inc} + (SW+1)'(rec_len) <= {1'b0, frame_size})) begin
            phase_d = PH_VALUE;
            kind_d  = tag_kind;
            cnt_d   = '0;
          end else begin
            phase_d = PH_STOPPED;
            stop_d  = 1'b1;
          end
        end
        PH_VALUE: begin
          words_d[widx][{cnt_q[1:0], 3'b000} +: 8] = in_i.data.byte_value;
          if (cnt_next >= rec_total) begin
            flags_d[kind_q] = 1'b1;
            phase_d         = PH_TAG;
            cnt_d           = '0;
          end else begin
            cnt_d = cnt_next[2:0];
          end
        end
        default: ;
      endcase

      if (frame_done) begin
        push     = 1'b1;
        frames_d = frames_q + WordW'(1);
      end else begin
        pos_d = pos_inc[PW-1:0];
      end
    end

    // The result reflects this byte's update, before the frame state clears.
    result.temperature_first     = words_d[0];
    result.temperature_second    = words_d[1];
    result.deflection_word       = words_d[2];
    result.pressure_word         = words_d[3];
    result.chip_temperature_word = words_d[4];
    result.has_temperature       = flags_d[KIND_T];
    result.has_deflection        = flags_d[KIND_D];
    result.has_pressure          = flags_d[KIND_P];
    result.has_chip_temperature  = flags_d[KIND_S];
    result.decode_stopped        = stop_d;
    result.message_count         = frames_d;

    if (push) begin
      pos_d   = '0;
      phase_d = PH_TAG;
      kind_d  = KIND_T;
      cnt_d   = '0;
      for (int w = 0; w < NumWords; w++) begin
        words_d[w] = '0;
      end
      flags_d = '0;
      stop_d  = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q    <= '0;
      phase_q  <= PH_TAG;
      kind_q   <= KIND_T;
      cnt_q    <= '0;
      for (int w = 0; w < NumWords; w++) begin
        words_q[w] <= '0;
      end
      flags_q  <= '0;
      stop_q   <= 1'b0;
      idle_q   <= '0;
      frames_q <= '0;
    end else begin
      pos_q    <= pos_d;
      phase_q  <= phase_d;
      kind_q   <= kind_d;
      cnt_q    <= cnt_d;
      words_q  <= words_d;
      flags_q  <= flags_d;
      stop_q   <= stop_d;
      idle_q   <= idle_d;
      frames_q <= frames_d;
    end
  end

  srfd_out_queue u_out_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .data_i (result),
    .full_o (q_full),
    .out_o  (out_o)
  );

  // The stop flag and the stopped phase are set and cleared together.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    stop_q == (phase_q == PH_STOPPED))
    else $error("stop flag out of step with decoder phase");

  // A single-word record never counts past its fourth value byte.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_VALUE && kind_q != KIND_T) |-> (cnt_q < 3'd4))
    else $error("value byte count overran a single-word record");

  // After a completed frame, a result is waiting at the output in the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |=> out_o.valid)
    else $error("completed frame did not reach the output");

  // Any accepted byte restarts the idle count.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && in_i.data.operation == OP_BYTE) |=> (idle_q == '0))
    else $error("idle counter not cleared by a byte");

endmodule

`default_nettype wire

// ===== design/srfd_out_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Two-entry result queue: the head drives the output channel, the second
// entry catches a result while the head is still stalled.
module srfd_out_queue (
  input  wire                    clk_i,
  input  wire                    rst_ni,
  input  wire                    push_i,
  input  srfd_pkg::result_t      data_i,
  output logic                   full_o,
  srfd_chan_if.source            out_o
);
  import srfd_pkg::*;

  result_t head_q, head_d;
  result_t tail_q, tail_d;
  logic    head_vld_q, head_vld_d;
  logic    tail_vld_q, tail_vld_d;
  logic    pop;

  assign pop       = head_vld_q && out_o.ready;
  assign full_o    = tail_vld_q;
  assign out_o.valid = head_vld_q;
  assign out_o.data  = head_q;

  always_comb begin
    head_d     = head_q;
    tail_d     = tail_q;
    head_vld_d = head_vld_q;
    tail_vld_d = tail_vld_q;
    if (pop) begin
      // The tail moves up; a push in the same cycle lands behind it or at the head.
      if (tail_vld_q) begin
        head_d     = tail_q;
        tail_vld_d = 1'b0;
        if (push_i) begin
          tail_d     = data_i;
          tail_vld_d = 1'b1;
        end
      end else if (push_i) begin
        head_d = data_i;
      end else begin
        head_vld_d = 1'b0;
      end
    end else if (push_i) begin
      if (!head_vld_q) begin
        head_d     = data_i;
        head_vld_d = 1'b1;
      end else begin
        tail_d     = data_i;
        tail_vld_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_vld_q <= 1'b0;
      tail_vld_q <= 1'b0;
    end else begin
      head_vld_q <= head_vld_d;
      tail_vld_q <= tail_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    head_q <= head_d;
    tail_q <= tail_d;
  end

endmodule

`default_nettype wire

// ===== dv/sensor_record_frame_decoder_checker.sv =====
`timescale 1ns / 1ps

// Watches the three channels of the frame decoder. It keeps its own copy of the
// frame state, works out the result beat of every completed frame, and compares
// each result beat field by field with the oldest frame still waiting.
module sensor_record_frame_decoder_checker #(
  parameter int unsigned MAX_PAYLOAD = 64
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_valid_i,
  input  logic                  cfg_ready_i,
  input  srfd_pkg::cfg_beat_t   cfg_data_i,
  input  logic                  in_valid_i,
  input  logic                  in_ready_i,
  input  srfd_pkg::in_beat_t    in_data_i,
  input  logic                  out_valid_i,
  input  logic                  out_ready_i,
  input  srfd_pkg::result_t     out_data_i,
  output int unsigned           fail_count_o,
  output int unsigned           pending_o
);
  import srfd_pkg::*;

  logic [PayloadSizeW-1:0] frame_len_reg;
  logic [IdleW-1:0]        idle_limit_reg;

  int unsigned      frame_pos;
  phase_e           phase;
  kind_e            kind;
  int unsigned      value_count;
  logic [WordW-1:0] words [NumWords];
  logic [3:0]       present;
  logic             stopped;
  logic [IdleW-1:0] idle_ticks;
  logic [WordW-1:0] frames_done;

  result_t frame_results_q [$];

  task automatic clear_frame();
    int i;
    frame_pos   = 0;
    phase       = PH_TAG;
    kind        = KIND_T;
    value_count = 0;
    for (i = 0; i < NumWords; i++) words[i] = '0;
    present = '0;
    stopped = 1'b0;
  endtask

  task automatic decode_byte(input logic [7:0] b, input int unsigned size);
    int unsigned len;
    int unsigned idx;
    int unsigned total;
    kind_e       k;
    bit          known;
    if (phase == PH_TAG) begin
      known = 1'b1;
      len   = LEN_SINGLE;
      k     = KIND_T;
      case (b)
        TAG_T: begin
          k   = KIND_T;
          len = LEN_DOUBLE;
        end
        TAG_D: k = KIND_D;
        TAG_P: k = KIND_P;
        TAG_S: k = KIND_S;
        default: known = 1'b0;
      endcase
      // The whole record has to fit in what is left of the frame.
      if (known && frame_pos + 1 + len <= size) begin
        phase       = PH_VALUE;
        kind        = k;
        value_count = 0;
      end else begin
        phase   = PH_STOPPED;
        stopped = 1'b1;
      end
    end else if (phase == PH_VALUE) begin
      total = (kind == KIND_T) ? LEN_DOUBLE : LEN_SINGLE;
      if (kind == KIND_T) idx = (value_count < 4) ? 0 : 1;
      else idx = int'(kind) + 1;
      words[idx][8*(value_count%4) +: 8] = b;
      value_count++;
      if (value_count >= total) begin
        present[kind] = 1'b1;
        phase         = PH_TAG;
        value_count   = 0;
      end
    end
  endtask

  task automatic take_input_beat(input in_beat_t beat);
    int unsigned size;
    result_t     r;
    if (beat.operation == OP_TICK) begin
      if (idle_ticks != '1) idle_ticks++;
      if (frame_pos > 0 && idle_ticks > idle_limit_reg) clear_frame();
    end else begin
      idle_ticks = '0;
      size = frame_len_reg;
      if (size == 0) size = 1;
      if (size > MAX_PAYLOAD) size = MAX_PAYLOAD;
      decode_byte(beat.byte_value, size);
      frame_pos++;
      if (frame_pos >= size) begin
        frames_done++;
        r.temperature_first     = words[0];
        r.temperature_second    = words[1];
        r.deflection_word       = words[2];
        r.pressure_word         = words[3];
        r.chip_temperature_word = words[4];
        r.has_temperature       = present[KIND_T];
        r.has_deflection        = present[KIND_D];
        r.has_pressure          = present[KIND_P];
        r.has_chip_temperature  = present[KIND_S];
        r.decode_stopped        = stopped;
        r.message_count         = frames_done;
        frame_results_q.push_back(r);
        clear_frame();
      end
    end
  endtask

  task automatic report_mismatch(input string what, input logic [WordW-1:0] got,
                                 input logic [WordW-1:0] want);
    fail_count_o++;
    $display("%0t frame result mismatch on %s: got %h, expected %h",
             $time, what, got, want);
  endtask

  task automatic check_field(input string name, input logic [WordW-1:0] got,
                             input logic [WordW-1:0] want);
    if (got !== want) report_mismatch(name, got, want);
  endtask

  task automatic compare_result(input result_t got);
    result_t want;
    if (frame_results_q.size() == 0) begin
      report_mismatch("result beat with no frame pending", got.message_count, '0);
    end else begin
      want = frame_results_q.pop_front();
      check_field("temperature_first", got.temperature_first, want.temperature_first);
      check_field("temperature_second", got.temperature_second, want.temperature_second);
      check_field("deflection_word", got.deflection_word, want.deflection_word);
      check_field("pressure_word", got.pressure_word, want.pressure_word);
      check_field("chip_temperature_word", got.chip_temperature_word,
                  want.chip_temperature_word);
      check_field("has_temperature", got.has_temperature, want.has_temperature);
      check_field("has_deflection", got.has_deflection, want.has_deflection);
      check_field("has_pressure", got.has_pressure, want.has_pressure);
      check_field("has_chip_temperature", got.has_chip_temperature,
                  want.has_chip_temperature);
      check_field("decode_stopped", got.decode_stopped, want.decode_stopped);
      check_field("message_count", got.message_count, want.message_count);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_len_reg  = PayloadSizeReset;
      idle_limit_reg = IdleLimitReset;
      idle_ticks     = '0;
      frames_done    = '0;
      clear_frame();
      frame_results_q.delete();
      fail_count_o = 0;
      pending_o    = 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        if (cfg_data_i.reg_index == CFG_PAYLOAD_SIZE)
          frame_len_reg = cfg_data_i.wr_data[PayloadSizeW-1:0];
        else if (cfg_data_i.reg_index == CFG_IDLE_LIMIT)
          idle_limit_reg = cfg_data_i.wr_data[IdleW-1:0];
      end
      if (in_valid_i && in_ready_i) take_input_beat(in_data_i);
      if (out_valid_i && out_ready_i) compare_result(out_data_i);
      pending_o = frame_results_q.size();
    end
  end

endmodule

// ===== dv/sensor_record_frame_decoder_test.sv =====
`timescale 1ns / 1ps

// Top of the frame decoder testbench. It makes the clock and the one reset,
// drives the configuration and input channels, plays the receiver on the
// result channel, and gives the verdict. All prediction and comparison lives
// in the checker instantiated next to the block.
//
// The run starts with a short directed part (frame size zero,
// full-width words, an idle drop, a record that does not fit, an unknown tag,
// and a frame size lowered in the middle of a frame). The random part then
// walks through many register settings and sends mostly well-formed frames
// of random records, mixed with junk bytes, noise and cut-off frames that are
// dropped by running past the idle limit.
module sensor_record_frame_decoder_test;
  import srfd_pkg::*;

  localparam int unsigned MaxPayload  = 64;
  localparam int unsigned RandomItems = 1850;
  localparam int unsigned PhaseItems  = 60;
  // Far above the slowest correct run.
  localparam int unsigned CycleLimit  = 200000;
  localparam int unsigned DrainCycles = 8;
  localparam int unsigned StallCycles = 200;

  logic clk;
  logic rst_n;

  srfd_chan_if #(.payload_t(cfg_beat_t)) cfg_if ();
  srfd_chan_if #(.payload_t(in_beat_t))  in_if ();
  srfd_chan_if #(.payload_t(result_t))   out_if ();

  int unsigned fail_count;
  int unsigned pending;

  // Knobs set by the stimulus; the receiver process reads recv_idle_pct and long_stall_go.
  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;
  int unsigned tick_pct;
  bit          long_stall_go;
  int unsigned items_sent;

  // What the stimulus needs to know of the current register settings.
  int unsigned      cur_frame_len;
  logic [IdleW-1:0] cur_idle_limit;

  sensor_record_frame_decoder #(
    .MAX_PAYLOAD(MaxPayload)
  ) dut (
    .clk_i (clk),
    .rst_ni(rst_n),
    .cfg_i (cfg_if.sink),
    .in_i  (in_if.sink),
    .out_o (out_if.source)
  );

  sensor_record_frame_decoder_checker #(
    .MAX_PAYLOAD(MaxPayload)
  ) u_checker (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_valid_i (cfg_if.valid),
    .cfg_ready_i (cfg_if.ready),
    .cfg_data_i  (cfg_if.data),
    .in_valid_i  (in_if.valid),
    .in_ready_i  (in_if.ready),
    .in_data_i   (in_if.data),
    .out_valid_i (out_if.valid),
    .out_ready_i (out_if.ready),
    .out_data_i  (out_if.data),
    .fail_count_o(fail_count),
    .pending_o   (pending)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Offer one beat on the input channel and return at the edge that takes it.
  // The sender may first idle at the rate send_idle_pct sets; valid stays high from one beat
  // to the next when it does not.
  task automatic send_beat(input logic op, input logic [7:0] b);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk);
    end
    in_if.valid <= 1'b1;
    in_if.data  <= {op, b};
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    items_sent++;
  endtask

  // The byte field of a tick is ignored by the block, so it carries random
  // bits to make sure that really holds.
  task automatic send_tick();
    send_beat(OP_TICK, 8'($urandom));
  endtask

  // A single tick between two bytes never reaches a limit of one or more,
  // so it can be slipped into a frame without breaking it.
  task automatic send_byte(input logic [7:0] b);
    if (cur_idle_limit >= 1 && $urandom_range(0, 99) < tick_pct) send_tick();
    send_beat(OP_BYTE, b);
  endtask

  task automatic send_word(input logic [WordW-1:0] w);
    int i;
    for (i = 0; i < 4; i++) send_byte(w[8*i +: 8]);
  endtask

  // Send nbytes bytes as a stream of records with random tags and values.
  // When a record no longer fits, its tag goes out anyway, which stops the
  // decoding of the frame, and the rest is filled the same way. With junk set,
  // some record starts are replaced by a random byte, mostly an unknown tag.
  task automatic emit_records(input int unsigned nbytes, input bit junk);
    int unsigned left;
    int unsigned len;
    logic [7:0]  tag;
    left = nbytes;
    while (left > 0) begin
      case ($urandom_range(0, 3))
        0:       tag = TAG_T;
        1:       tag = TAG_D;
        2:       tag = TAG_P;
        default: tag = TAG_S;
      endcase
      len = (tag == TAG_T) ? LEN_DOUBLE : LEN_SINGLE;
      if (junk && $urandom_range(0, 7) == 0) begin
        send_byte(8'($urandom));
        left--;
      end else if (1 + len <= left) begin
        send_byte(tag);
        if (tag == TAG_T) send_word($urandom);
        send_word($urandom);
        left -= 1 + len;
      end else begin
        send_byte(tag);
        left--;
      end
    end
  endtask

  // One random frame worth of input. Noise and cut-off frames keep the byte
  // count of a frame, or end in a drop, so the next frame starts aligned.
  task automatic send_frame();
    int unsigned pick;
    int unsigned cut;
    pick = $urandom_range(0, 99);
    if (pick < 12 && cur_idle_limit <= 40) begin
      // A partial frame followed by enough silence to have it thrown away.
      cut = $urandom_range(0, cur_frame_len - 1);
      emit_records(cut, 1'b0);
      repeat (cur_idle_limit + 1 + $urandom_range(0, 2)) send_tick();
    end else if (pick < 24) begin
      // Raw noise: random bytes of a full frame with ticks between them.
      repeat (cur_frame_len) begin
        if ($urandom_range(0, 3) == 0) send_tick();
        send_beat(OP_BYTE, 8'($urandom));
      end
    end else if (pick < 36) begin
      emit_records(cur_frame_len, 1'b1);
    end else begin
      emit_records(cur_frame_len, 1'b0);
    end
  endtask

  // Stop offering input and wait until every predicted frame has come out.
  // The check is made at the falling edge, after the checker has updated.
  // The rising edges waited on after that cover the beat that is still inside the block.
  task automatic settle_block();
    in_if.valid <= 1'b0;
    do @(negedge clk); while (pending != 0);
    repeat (4) @(posedge clk);
  endtask

  // Write both registers while the block is idle. The upper bits of the
  // frame size word are don't-care bits for the block.
  task automatic configure(input logic [CfgDataW-1:0] size_word,
                           input logic [CfgDataW-1:0] limit_word);
    settle_block();
    cfg_if.valid <= 1'b1;
    cfg_if.data  <= {CFG_PAYLOAD_SIZE, size_word};
    @(posedge clk);
    while (!cfg_if.ready) @(posedge clk);
    cfg_if.data <= {CFG_IDLE_LIMIT, limit_word};
    @(posedge clk);
    while (!cfg_if.ready) @(posedge clk);
    cfg_if.valid <= 1'b0;
    cur_frame_len = size_word[PayloadSizeW-1:0];
    if (cur_frame_len == 0) cur_frame_len = 1;
    if (cur_frame_len > MaxPayload) cur_frame_len = MaxPayload;
    cur_idle_limit = limit_word;
  endtask

  // The receiver. It idles at the rate the stimulus sets, and once, on
  // request, holds off for a long stretch so that the output queue fills and
  // the block has to stall its input.
  initial begin : receiver
    int unsigned stall_left;
    bit          stall_taken;
    stall_left  = 0;
    stall_taken = 1'b0;
    out_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (long_stall_go && !stall_taken) begin
        stall_left  = StallCycles;
        stall_taken = 1'b1;
      end
      if (stall_left > 0) begin
        stall_left--;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
    end
  end

  // Ends a run that hangs, for example on a frame that never comes out.
  initial begin : watchdog
    int unsigned cycles;
    cycles = 0;
    while (cycles < CycleLimit) begin
      @(posedge clk);
      cycles++;
    end
    $display("sensor_record_frame_decoder test failed");
    $finish;
  end

  initial begin : stimulus
    int unsigned      rand_start;
    int unsigned      phase_start;
    int unsigned      pick;
    logic [6:0]       size7;
    logic [IdleW-1:0] limit;

    cfg_if.valid <= 1'b0;
    cfg_if.data  <= '0;
    in_if.valid  <= 1'b0;
    in_if.data   <= '0;
    rst_n        <= 1'b0;
    send_idle_pct  = 0;
    recv_idle_pct  = 0;
    tick_pct       = 0;
    long_stall_go  = 1'b0;
    items_sent     = 0;
    cur_frame_len  = PayloadSizeReset;
    cur_idle_limit = IdleLimitReset;

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Frame size zero acts as one: every byte is a frame. A 'T' cannot fit
    // and an unknown tag stops at once, so both frames report a stop.
    configure(16'hFF80, 16'd2);
    send_byte(TAG_T);
    send_byte(8'hFF);

    // A full temperature record with all-ones and all-zeros words.
    configure(16'd9, 16'd2);
    send_byte(TAG_T);
    send_word(32'hFFFF_FFFF);
    send_word(32'h0000_0000);

    // A partial frame dropped on the third tick, then a tick with no frame.
    send_byte(TAG_D);
    send_byte(8'h00);
    repeat (4) send_tick();

    // A deflection record, then a chip temperature record that does not fit.
    configure(16'd6, 16'hFFFF);
    send_byte(TAG_D);
    send_word(32'h8000_0001);
    send_byte(TAG_S);

    // Lowering the frame size in the middle of a pressure record: the next
    // byte ends the frame and the cut record is not marked present.
    configure(16'd24, 16'd100);
    send_byte(TAG_P);
    send_byte(8'h5A);
    send_byte(8'hC3);
    configure(16'd2, 16'd100);
    send_byte(8'h7E);

    // Random part, in three stretches of idling: a slow receiver, then a slow
    // sender, then no idling at all with one long receiver hold-off.
    tick_pct   = 5;
    rand_start = items_sent;
    while (items_sent - rand_start < RandomItems) begin
      if (items_sent - rand_start < RandomItems / 3) begin
        send_idle_pct = 18;
        recv_idle_pct = 73;
      end else if (items_sent - rand_start < 2 * RandomItems / 3) begin
        send_idle_pct = 73;
        recv_idle_pct = 18;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
        if (!long_stall_go) begin
          // Two-byte frames give a result every other beat, so the output
          // queue fills quickly once the receiver stops taking beats.
          configure(16'd2, 16'd100);
          long_stall_go = 1'b1;
          repeat (60) emit_records(2, 1'b0);
        end
      end

      pick = $urandom_range(0, 99);
      if (pick < 4) size7 = 7'd0;
      else if (pick < 8) size7 = 7'd127;
      else if (pick < 13) size7 = 7'd64;
      else if (pick < 17) size7 = 7'($urandom_range(65, 126));
      else if (pick < 24) size7 = 7'd1;
      else size7 = 7'($urandom_range(2, 20));

      pick = $urandom_range(0, 99);
      if (pick < 10) limit = 16'hFFFF;
      else if (pick < 15) limit = 16'd0;
      else if (pick < 25) limit = 16'($urandom);
      else limit = 16'($urandom_range(1, 30));

      configure({7'($urandom_range(0, 127)), 2'($urandom_range(0, 3)), size7}, limit);
      phase_start = items_sent;
      while (items_sent - phase_start < PhaseItems) send_frame();
    end

    settle_block();
    repeat (DrainCycles) @(posedge clk);
    if (fail_count == 0) begin
      $display("sensor_record_frame_decoder test passed");
    end else begin
      $display("sensor_record_frame_decoder test failed");
    end
    $finish;
  end

endmodule
